FILE: rtl/tbd_pkg.sv
package tbd_pkg;

  localparam logic [2:0] PH_HDR   = 3'd0;
  localparam logic [2:0] PH_DEF   = 3'd1;
  localparam logic [2:0] PH_FLAGS = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_RAW   = 3'd4;

  localparam logic [7:0] HDR_SKIP_MIN = 8'hc0;
  localparam logic [7:0] HDR_RAW      = 8'h2a;
  localparam int unsigned StoreDepth  = 9;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_PLANES,
    ACC_ROWS,
    ACC_EMIT
  } acc_kind_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_PLANES,
    OP_REPLAY,
    OP_ROWS,
    OP_FINISH,
    OP_RAW_CLR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel_partner;
  } dp_cmd_t;

  typedef struct packed {
    acc_kind_e acc_kind;
    logic      coded;
    logic      replay;
    logic      rp_last;
    logic      row_step;
    logic      rows_full;
    logic      odd;
    logic      last;
  } dp_status_t;

  function automatic logic [7:0] short_def(input logic [1:0] sel);
    logic [7:0] r;
    unique case (sel)
      2'd0: r = 8'h00;
      2'd1: r = 8'h55;
      2'd2: r = 8'haa;
      default: r = 8'hff;
    endcase
    return r;
  endfunction

  // 8x8 bit matrix transpose: bit 8i+j of result is bit 8j+i of v
  function automatic logic [63:0] transpose_plane(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        r[8*i+j] = v[8*j+i];
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/tbd_stream_if.sv
interface tbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface tbd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_plane;
  logic        block_last;
  modport source (output valid, output out_plane, output block_last, input ready);
  modport sink (input valid, input out_plane, input block_last, output ready);
endinterface

FILE: rtl/tbd_datapath.sv
module tbd_datapath import tbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [7:0]  in_byte_i,
  output dp_status_t  status_o,
  output logic [63:0] out_plane_o,
  output logic        block_last_o
);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  header_q, header_d;
  logic [7:0]  def_q, def_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  run_byte_q, run_byte_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [2:0]  pi_q, pi_d;
  logic [63:0] work_q, work_d;
  logic [63:0] partner_q, partner_d;
  logic [3:0]  len_q, len_d;
  logic        last_q, last_d;
  logic [7:0]  rp_flags_q, rp_flags_d;
  logic [7:0]  rp_b_q, rp_b_d;
  logic [3:0]  rp_idx_q, rp_idx_d;
  logic [2:0]  rp_cnt_q, rp_cnt_d;
  logic [7:0]  store_q [StoreDepth];
  logic        store_we;

  logic        shared;
  logic [63:0] fill;
  logic [7:0]  store_rd;
  logic [63:0] v_t, v_pn, v_out;
  acc_kind_e   acc_kind;

  assign shared   = header_q[2] & header_q[1];
  assign fill     = {64{pi_q[0] ? header_q[4] : header_q[5]}};
  assign store_rd = (rp_idx_q < 4'(StoreDepth)) ? store_q[rp_idx_q] : 8'h00;
  assign store_we = cmd_i.op == OP_ACCEPT && (phase_q == PH_FLAGS || phase_q == PH_DATA)
                    && shared && len_q < 4'(StoreDepth);
  assign v_t   = header_q[0] ? transpose_plane(work_q) : work_q;
  assign v_pn  = header_q[7] ? (partner_q ^ v_t) : partner_q;
  assign v_out = header_q[6] ? (v_t ^ v_pn) : v_t;

  always_comb begin
    acc_kind = ACC_NONE;
    unique case (phase_q)
      PH_HDR: begin
        if (in_byte_i < HDR_SKIP_MIN && in_byte_i != HDR_RAW && !in_byte_i[1]) begin
          acc_kind = ACC_PLANES;
        end
      end
      PH_DEF:   acc_kind = ACC_PLANES;
      PH_FLAGS: acc_kind = ACC_ROWS;
      PH_DATA:  acc_kind = ACC_ROWS;
      PH_RAW:   acc_kind = (cnt_q[2:0] == 3'd7) ? ACC_EMIT : ACC_NONE;
      default:  acc_kind = ACC_NONE;
    endcase
  end

  always_comb begin
    status_o.acc_kind  = acc_kind;
    status_o.coded     = def_q[7];
    status_o.replay    = shared && len_q != 4'd0;
    status_o.rp_last   = rp_cnt_q == 3'd7;
    status_o.row_step  = cnt_q < 7'd8 && !flags_q[7];
    status_o.rows_full = cnt_q >= 7'd8;
    status_o.odd       = pi_q[0];
    status_o.last      = last_q;
  end

  assign out_plane_o  = cmd_i.sel_partner ? partner_q : work_q;
  assign block_last_o = cmd_i.sel_partner ? 1'b0 : last_q;

  always_comb begin
    phase_d    = phase_q;
    header_d   = header_q;
    def_d      = def_q;
    flags_d    = flags_q;
    run_byte_d = run_byte_q;
    cnt_d      = cnt_q;
    pi_d       = pi_q;
    work_d     = work_q;
    partner_d  = partner_q;
    len_d      = store_we ? len_q + 4'd1 : len_q;
    last_d     = last_q;
    rp_flags_d = rp_flags_q;
    rp_b_d     = rp_b_q;
    rp_idx_d   = rp_idx_q;
    rp_cnt_d   = rp_cnt_q;
    unique case (cmd_i.op)
      OP_ACCEPT: begin
        unique case (phase_q)
          PH_HDR: begin
            if (in_byte_i == HDR_RAW) begin
              phase_d = PH_RAW;
              cnt_d   = '0;
              work_d  = '0;
            end else if (in_byte_i < HDR_SKIP_MIN) begin
              header_d  = in_byte_i;
              pi_d      = '0;
              partner_d = '0;
              len_d     = '0;
              if (in_byte_i[1]) begin
                phase_d = PH_DEF;
              end else begin
                def_d = short_def(in_byte_i[3:2]);
              end
            end
          end
          PH_DEF: def_d = in_byte_i;
          PH_FLAGS: begin
            flags_d    = in_byte_i;
            run_byte_d = work_q[7:0];
            cnt_d      = '0;
          end
          PH_DATA: begin
            run_byte_d = in_byte_i;
            work_d     = {work_q[55:0], in_byte_i};
            flags_d    = {flags_q[6:0], 1'b0};
            cnt_d      = cnt_q + 7'd1;
          end
          PH_RAW: begin
            for (int k = 0; k < 8; k++) begin
              if (cnt_q[2:0] == 3'(k)) begin
                work_d[8*k +: 8] = work_q[8*k +: 8] | in_byte_i;
              end
            end
            last_d = cnt_q >= 7'd63;
            if (cnt_q >= 7'd63) begin
              cnt_d   = '0;
              phase_d = PH_HDR;
            end else begin
              cnt_d = cnt_q + 7'd1;
            end
          end
          default: phase_d = PH_HDR;
        endcase
      end
      OP_PLANES: begin
        work_d = fill;
        if (def_q[7]) begin
          if (!(shared && len_q != 4'd0)) begin
            phase_d = PH_FLAGS;
          end else begin
            rp_flags_d = store_q[0];
            rp_b_d     = fill[7:0];
            rp_idx_d   = 4'd1;
            rp_cnt_d   = '0;
          end
        end
      end
      OP_REPLAY: begin
        if (rp_flags_q[7]) begin
          rp_b_d   = store_rd;
          rp_idx_d = rp_idx_q + 4'd1;
          work_d   = {work_q[55:0], store_rd};
        end else begin
          work_d = {work_q[55:0], rp_b_q};
        end
        rp_flags_d = {rp_flags_q[6:0], 1'b0};
        rp_cnt_d   = rp_cnt_q + 3'd1;
      end
      OP_ROWS: begin
        if (cnt_q < 7'd8 && !flags_q[7]) begin
          work_d  = {work_q[55:0], run_byte_q};
          flags_d = {flags_q[6:0], 1'b0};
          cnt_d   = cnt_q + 7'd1;
        end else if (cnt_q < 7'd8) begin
          phase_d = PH_DATA;
        end
      end
      OP_FINISH: begin
        if (pi_q[0]) begin
          partner_d = v_pn;
          work_d    = v_out;
          last_d    = pi_q == 3'd7;
        end else begin
          partner_d = v_t;
        end
        def_d = {def_q[6:0], 1'b0};
        if (pi_q == 3'd7) begin
          pi_d    = '0;
          phase_d = PH_HDR;
        end else begin
          pi_d = pi_q + 3'd1;
        end
      end
      OP_RAW_CLR: work_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR;
      header_q   <= '0;
      def_q      <= '0;
      flags_q    <= '0;
      run_byte_q <= '0;
      cnt_q      <= '0;
      pi_q       <= '0;
      work_q     <= '0;
      partner_q  <= '0;
      len_q      <= '0;
      last_q     <= 1'b0;
      rp_flags_q <= '0;
      rp_b_q     <= '0;
      rp_idx_q   <= '0;
      rp_cnt_q   <= '0;
    end else begin
      phase_q    <= phase_d;
      header_q   <= header_d;
      def_q      <= def_d;
      flags_q    <= flags_d;
      run_byte_q <= run_byte_d;
      cnt_q      <= cnt_d;
      pi_q       <= pi_d;
      work_q     <= work_d;
      partner_q  <= partner_d;
      len_q      <= len_d;
      last_q     <= last_d;
      rp_flags_q <= rp_flags_d;
      rp_b_q     <= rp_b_d;
      rp_idx_q   <= rp_idx_d;
      rp_cnt_q   <= rp_cnt_d;
    end
  end

  // shared packed-run store, no reset
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[len_q] <= in_byte_i;
    end
  end

endmodule

FILE: rtl/tbd_ctrl.sv
module tbd_ctrl import tbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PLANES = 3'd1;
  localparam logic [2:0] S_REPLAY = 3'd2;
  localparam logic [2:0] S_ROWS   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_EMIT_A = 3'd5;
  localparam logic [2:0] S_EMIT_B = 3'd6;

  logic [2:0] state_q, state_d;
  logic       raw_q, raw_d;
  logic       in_fire, out_fire;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_EMIT_A || state_q == S_EMIT_B;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  always_comb begin
    state_d           = state_q;
    raw_d             = raw_q;
    cmd_o.op          = OP_NONE;
    cmd_o.sel_partner = state_q == S_EMIT_A;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.op = OP_ACCEPT;
          unique case (status_i.acc_kind)
            ACC_PLANES: state_d = S_PLANES;
            ACC_ROWS:   state_d = S_ROWS;
            ACC_EMIT: begin
              state_d = S_EMIT_B;
              raw_d   = 1'b1;
            end
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_PLANES: begin
        cmd_o.op = OP_PLANES;
        if (status_i.coded && !status_i.replay) begin
          state_d = S_IDLE;
        end else if (status_i.coded) begin
          state_d = S_REPLAY;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_REPLAY: begin
        cmd_o.op = OP_REPLAY;
        if (status_i.rp_last) state_d = S_FINISH;
      end
      S_ROWS: begin
        cmd_o.op = OP_ROWS;
        priority if (status_i.row_step) begin
          state_d = S_ROWS;
        end else if (status_i.rows_full) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FINISH: begin
        cmd_o.op = OP_FINISH;
        raw_d    = 1'b0;
        state_d  = status_i.odd ? S_EMIT_A : S_PLANES;
      end
      S_EMIT_A: begin
        if (out_fire) state_d = S_EMIT_B;
      end
      S_EMIT_B: begin
        if (out_fire) begin
          if (raw_q) begin
            cmd_o.op = OP_RAW_CLR;
            state_d  = S_IDLE;
          end else if (status_i.last) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_PLANES;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      raw_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      raw_q   <= raw_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while emitting");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_A && out_ready_i) |=> state_q == S_EMIT_B)
    else $error("odd plane did not follow even plane");

  a_raw_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_B && out_ready_i && raw_q) |=> state_q == S_IDLE)
    else $error("raw row did not return to idle");

endmodule

FILE: rtl/tile_block_decompressor.sv
// Tile block decompressor.
// in_i  : one compressed stream byte per item (valid/ready).
// out_o : decoded 64-bit planes, block_last set on the eighth plane of a block.
// A header, definition or raw byte that yields nothing keeps the input
// ready. A flags or packed-run byte is followed by a row step per repeated
// row and a closing step that waits for the next byte or finishes the plane.
// Each plane passes a plan step and a finish step; a replayed shared plane
// adds eight packed rows, one per cycle through the shared store.
// Each odd plane emits two items, one per cycle while out_o.ready is high.
// A raw block emits one item after every 8th byte.
// Input is taken only while no decode work or output is pending, so one
// byte is in flight at a time; the sequencer, not the stream, sets the rate.
// Reset returns the block to waiting for a header; the shared store is
// left as is and only read after it is written in the same block.
// A stalled receiver holds the current item on out_o and freezes decode.
module tile_block_decompressor import tbd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tbd_in_if.sink    in_i,
  tbd_out_if.source out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: handshakes and step order
  tbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: block state, packed-run rows, transpose and XOR pairing
  tbd_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_byte_i    (in_i.in_byte),
    .status_o     (status),
    .out_plane_o  (out_o.out_plane),
    .block_last_o (out_o.block_last)
  );

endmodule
